// File: rtl/murmur3_32bit_hash_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the MurmurHash3 block
// Same-cycle and next-cycle implication checks on clk_i, off during reset.
// ---------------------------------------------------------------------------
`ifndef MURMUR3_32BIT_HASH_ASSERT_SVH
`define MURMUR3_32BIT_HASH_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define MM3_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mm3 assertion failed");

// antecedent implies consequent in the next cycle
`define MM3_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mm3 assertion failed");

`endif

// File: rtl/mm3_pkg.sv
// ---------------------------------------------------------------------------
// mm3_pkg
// Constants, sequencer states and control types of the MurmurHash3 block.
// ---------------------------------------------------------------------------
package mm3_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 3;

  localparam logic [WordW-1:0] MixC1  = 32'hcc9e2d51;
  localparam logic [WordW-1:0] MixC2  = 32'h1b873593;
  localparam logic [WordW-1:0] MixAdd = 32'he6546b64;
  localparam logic [WordW-1:0] FinM1  = 32'h85ebca6b;
  localparam logic [WordW-1:0] FinM2  = 32'hc2b2ae35;

  typedef enum logic [2:0] {
    S_IDLE,
    S_K1,
    S_K2,
    S_MIX,
    S_F1,
    S_F2,
    S_OUT
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_K1,
    OP_K2,
    OP_MIX,
    OP_F1,
    OP_F2,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic last;
    logic out_busy;
  } status_t;

endpackage

// File: rtl/mm3_in_if.sv
// ---------------------------------------------------------------------------
// mm3_in_if
// Input channel: one message word per transaction with framing bits.
// ---------------------------------------------------------------------------
interface mm3_in_if;
  logic                           valid;
  logic                           ready;
  logic [mm3_pkg::WordW-1:0]      seed;
  logic                           first_word;
  logic [mm3_pkg::WordW-1:0]      data_word;
  logic [mm3_pkg::CountW-1:0]     valid_bytes;
  logic                           last_word;

  modport source (
    output valid, seed, first_word, data_word, valid_bytes, last_word,
    input  ready
  );
  modport sink (
    input  valid, seed, first_word, data_word, valid_bytes, last_word,
    output ready
  );
endinterface

// File: rtl/mm3_out_if.sv
// ---------------------------------------------------------------------------
// mm3_out_if
// Output channel: one finalized hash per transaction.
// ---------------------------------------------------------------------------
interface mm3_out_if;
  logic                      valid;
  logic                      ready;
  logic [mm3_pkg::WordW-1:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

// File: rtl/murmur3_32bit_hash.sv
// ---------------------------------------------------------------------------
// murmur3_32bit_hash
// Streaming MurmurHash3 x86_32 over little-endian 32-bit message words.
// ---------------------------------------------------------------------------
// Usage:
//   in_i  carries one message word per transaction: data_word with
//         valid_bytes (0..4, first byte in bits 7:0), first_word to load
//         seed and restart the length count, last_word on the closing word.
//   out_o carries one finalized hash_value per message.
// Timing: a word takes the accept step plus three steps of the shared
//   multiplier (c1, c2, mix); the next word is taken only once the
//   sequencer is back in idle. A last word adds two finalize multiplies
//   and a load of the output register: the hash appears there as the
//   sequencer returns to idle, where a new word can be taken.
// Stall: the finished hash sits in an output register; a new word is
//   accepted while it waits. A second finished hash waits in the
//   sequencer until the register frees, holding off further input.
// Reset: running hash and length clear to zero, output goes invalid.
// ---------------------------------------------------------------------------
module murmur3_32bit_hash (
  input  logic      clk_i,
  input  logic      rst_ni,
  mm3_in_if.sink    in_i,
  mm3_out_if.source out_o
);

  mm3_pkg::cmd_t    cmd;
  mm3_pkg::status_t status;

  mm3_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  mm3_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status),
    .in_i     (in_i),
    .out_o    (out_o)
  );

endmodule

// File: rtl/mm3_ctrl.sv
// ---------------------------------------------------------------------------
// mm3_ctrl
// Sequencer: steps the shared multiplier through body and finalize phases.
// ---------------------------------------------------------------------------
`include "murmur3_32bit_hash_assert.svh"

module mm3_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mm3_pkg::status_t status_i,
  output mm3_pkg::cmd_t    cmd_o
);

  mm3_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mm3_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mm3_pkg::S_IDLE: begin
        if (status_i.in_valid) state_d = mm3_pkg::S_K1;
      end
      mm3_pkg::S_K1:  state_d = mm3_pkg::S_K2;
      mm3_pkg::S_K2:  state_d = mm3_pkg::S_MIX;
      mm3_pkg::S_MIX: state_d = status_i.last ? mm3_pkg::S_F1 : mm3_pkg::S_IDLE;
      mm3_pkg::S_F1:  state_d = mm3_pkg::S_F2;
      mm3_pkg::S_F2:  state_d = mm3_pkg::S_OUT;
      mm3_pkg::S_OUT: begin
        if (!status_i.out_busy) state_d = mm3_pkg::S_IDLE;
      end
      default: state_d = mm3_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op = mm3_pkg::OP_NONE;
    unique case (state_q)
      mm3_pkg::S_IDLE: cmd_o.op = mm3_pkg::OP_LOAD;
      mm3_pkg::S_K1:   cmd_o.op = mm3_pkg::OP_K1;
      mm3_pkg::S_K2:   cmd_o.op = mm3_pkg::OP_K2;
      mm3_pkg::S_MIX:  cmd_o.op = mm3_pkg::OP_MIX;
      mm3_pkg::S_F1:   cmd_o.op = mm3_pkg::OP_F1;
      mm3_pkg::S_F2:   cmd_o.op = mm3_pkg::OP_F2;
      mm3_pkg::S_OUT: begin
        // hold the hash until the output register has room
        if (!status_i.out_busy) cmd_o.op = mm3_pkg::OP_EMIT;
      end
      default: cmd_o.op = mm3_pkg::OP_NONE;
    endcase
  end

  `MM3_ASSERT_NEXT(a_accept_to_k1,
                   state_q == mm3_pkg::S_IDLE && status_i.in_valid,
                   state_q == mm3_pkg::S_K1)
  `MM3_ASSERT_SAME(a_fin_only_last, state_q == mm3_pkg::S_F1, status_i.last)
  `MM3_ASSERT_NEXT(a_emit_to_idle,
                   state_q == mm3_pkg::S_OUT && !status_i.out_busy,
                   state_q == mm3_pkg::S_IDLE)

endmodule

// File: rtl/mm3_dp.sv
// ---------------------------------------------------------------------------
// mm3_dp
// Datapath: hash and length state, work register, one shared 32x32
// multiplier and the output register.
// ---------------------------------------------------------------------------
`include "murmur3_32bit_hash_assert.svh"

module mm3_dp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mm3_pkg::cmd_t    cmd_i,
  output mm3_pkg::status_t status_o,
  mm3_in_if.sink           in_i,
  mm3_out_if.source        out_o
);

  function automatic logic [mm3_pkg::WordW-1:0] rotl15(input logic [mm3_pkg::WordW-1:0] v);
    rotl15 = {v[16:0], v[31:17]};
  endfunction

  function automatic logic [mm3_pkg::WordW-1:0] rotl13(input logic [mm3_pkg::WordW-1:0] v);
    rotl13 = {v[18:0], v[31:19]};
  endfunction

  logic [mm3_pkg::WordW-1:0]  hash_q, hash_d;
  logic [mm3_pkg::WordW-1:0]  count_q, count_d;
  logic [mm3_pkg::WordW-1:0]  k_q, k_d;
  logic                       full_q, full_d;
  logic                       last_q, last_d;
  logic                       out_valid_q, out_valid_d;
  logic [mm3_pkg::WordW-1:0]  out_hash_q, out_hash_d;

  logic                       accept;
  logic [mm3_pkg::CountW-1:0] nbytes;
  logic [mm3_pkg::WordW-1:0]  masked;
  logic [mm3_pkg::WordW-1:0]  mul_a, mul_b, product;
  logic [mm3_pkg::WordW-1:0]  mix_x, mix_r, fin_x;

  assign in_i.ready = (cmd_i.op == mm3_pkg::OP_LOAD);
  assign accept     = in_i.valid && in_i.ready;

  // counts above four are taken as a full word
  assign nbytes = in_i.valid_bytes[2] ? mm3_pkg::CountW'(4)
                                      : {1'b0, in_i.valid_bytes[1:0]};

  always_comb begin
    unique case (nbytes)
      3'd1:    masked = {24'd0, in_i.data_word[7:0]};
      3'd2:    masked = {16'd0, in_i.data_word[15:0]};
      3'd3:    masked = {8'd0,  in_i.data_word[23:0]};
      3'd4:    masked = in_i.data_word;
      default: masked = '0;
    endcase
  end

  // finalize prelude: fold in the length, then the first xor-shift
  assign fin_x = hash_q ^ count_q;

  always_comb begin
    mul_a = k_q;
    mul_b = mm3_pkg::MixC1;
    unique case (cmd_i.op)
      mm3_pkg::OP_K2: begin
        mul_a = rotl15(k_q);
        mul_b = mm3_pkg::MixC2;
      end
      mm3_pkg::OP_F1: begin
        mul_a = fin_x ^ (fin_x >> 16);
        mul_b = mm3_pkg::FinM1;
      end
      mm3_pkg::OP_F2: begin
        mul_a = k_q ^ (k_q >> 13);
        mul_b = mm3_pkg::FinM2;
      end
      default: begin
        mul_a = k_q;
        mul_b = mm3_pkg::MixC1;
      end
    endcase
  end

  assign product = mul_a * mul_b;

  assign mix_x = hash_q ^ k_q;
  assign mix_r = rotl13(mix_x);

  always_comb begin
    hash_d      = hash_q;
    count_d     = count_q;
    k_d         = k_q;
    full_d      = full_q;
    last_d      = last_q;
    out_hash_d  = out_hash_q;
    out_valid_d = out_valid_q && !out_o.ready;
    unique case (cmd_i.op)
      mm3_pkg::OP_LOAD: begin
        if (accept) begin
          if (in_i.first_word) begin
            hash_d  = in_i.seed;
            count_d = mm3_pkg::WordW'(nbytes);
          end else begin
            count_d = count_q + mm3_pkg::WordW'(nbytes);
          end
          k_d    = masked;
          full_d = (nbytes == mm3_pkg::CountW'(4));
          last_d = in_i.last_word;
        end
      end
      mm3_pkg::OP_K1, mm3_pkg::OP_K2, mm3_pkg::OP_F1, mm3_pkg::OP_F2: begin
        k_d = product;
      end
      mm3_pkg::OP_MIX: begin
        // an empty item leaves k at zero, so the xor is a no-op
        if (full_q) hash_d = mix_r + {mix_r[29:0], 2'b00} + mm3_pkg::MixAdd;
        else        hash_d = mix_x;
      end
      mm3_pkg::OP_EMIT: begin
        out_hash_d  = k_q ^ (k_q >> 16);
        out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      hash_q      <= hash_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q        <= k_d;
    full_q     <= full_d;
    out_hash_q <= out_hash_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.hash_value = out_hash_q;

  assign status_o.in_valid = in_i.valid;
  assign status_o.last     = last_q;
  assign status_o.out_busy = out_valid_q && !out_o.ready;

endmodule
